// ----- sv/utf8d_pkg.sv -----
// Types, constants and helper functions for the UTF-8 stream decoder.
// No dependencies; used by utf8d_step and utf8_stream_decoder.
`default_nettype none

package utf8d_pkg;

   // Field widths.
   localparam int unsigned CpWidth  = 31;
   localparam int unsigned LenWidth = 3;

   // Byte-level codes.
   localparam logic [1:0] ContTag   = 2'b10;
   localparam logic [7:0] AsciiMax  = 8'h7f;

   // Sequence lengths.
   localparam logic [LenWidth-1:0] LenNone = 3'd0;
   localparam logic [LenWidth-1:0] LenOne  = 3'd1;
   localparam logic [LenWidth-1:0] LenTwo  = 3'd2;
   localparam logic [LenWidth-1:0] LenThree = 3'd3;
   localparam logic [LenWidth-1:0] LenFour = 3'd4;
   localparam logic [LenWidth-1:0] LenFive = 3'd5;
   localparam logic [LenWidth-1:0] LenSix  = 3'd6;

   // State of the open sequence.
   typedef struct packed {
      logic [LenWidth-1:0] exp_len;
      logic [LenWidth-1:0] seen;
      logic [CpWidth-1:0]  acc;
      logic                err;
   } seq_type;

   // One result item.
   typedef struct packed {
      logic [CpWidth-1:0]  code_point;
      logic                valid_res;
      logic [LenWidth-1:0] byte_count;
   } result_type;

   // Decoded lead byte: length (zero for an invalid lead) and payload mask.
   typedef struct packed {
      logic [LenWidth-1:0] len;
      logic [7:0]          mask;
   } lead_type;

   function automatic lead_type lead_decode(input logic [7:0] b);
      lead_type info;
      info.len  = LenNone;
      info.mask = 8'h00;
      priority if (b <= AsciiMax) begin
         info.len  = LenOne;
         info.mask = 8'h7f;
      end else if (b[7:5] == 3'b110) begin
         info.len  = LenTwo;
         info.mask = 8'h1f;
      end else if (b[7:4] == 4'b1110) begin
         info.len  = LenThree;
         info.mask = 8'h0f;
      end else if (b[7:3] == 5'b11110) begin
         info.len  = LenFour;
         info.mask = 8'h07;
      end else if (b[7:2] == 6'b111110) begin
         info.len  = LenFive;
         info.mask = 8'h03;
      end else if (b[7:1] == 7'b1111110) begin
         info.len  = LenSix;
         info.mask = 8'h01;
      end else begin
         // Continuation bytes, 0xFE and 0xFF cannot start a sequence.
         info.len  = LenNone;
         info.mask = 8'h00;
      end
      return info;
   endfunction

   // Smallest legal code point for a given length.
   function automatic logic [CpWidth-1:0] low_bound(input logic [LenWidth-1:0] len);
      logic [CpWidth-1:0] v;
      unique case (len)
         LenTwo:   v = 31'h0000_0080;
         LenThree: v = 31'h0000_0800;
         LenFour:  v = 31'h0001_0000;
         LenFive:  v = 31'h0020_0000;
         LenSix:   v = 31'h0400_0000;
         default:  v = '0;
      endcase
      return v;
   endfunction

   // Largest legal code point for a given length.
   function automatic logic [CpWidth-1:0] high_bound(input logic [LenWidth-1:0] len);
      logic [CpWidth-1:0] v;
      unique case (len)
         LenOne:   v = 31'h0000_007f;
         LenTwo:   v = 31'h0000_07ff;
         LenThree: v = 31'h0000_ffff;
         LenFour:  v = 31'h001f_ffff;
         LenFive:  v = 31'h03ff_ffff;
         LenSix:   v = 31'h7fff_ffff;
         default:  v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- sv/utf8d_step.sv -----
// Combinational per-byte update of the UTF-8 decoder sequence state.
// Depends on utf8d_pkg for the state, result and lead types.
`default_nettype none

module utf8d_step (
   input  wire utf8d_pkg::seq_type    seq_cur,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  end_of_buffer,
   output utf8d_pkg::seq_type         seq_next,
   output utf8d_pkg::result_type      res,
   output logic                       res_gen
);

   utf8d_pkg::lead_type              lead;
   logic                             is_open;
   logic                             is_cont;
   logic [utf8d_pkg::LenWidth-1:0]   seen_inc;
   logic                             err_upd;
   logic [utf8d_pkg::CpWidth-1:0]    acc_upd;
   logic                             in_range;

   assign lead     = utf8d_pkg::lead_decode(data_byte);
   assign is_open  = (seq_cur.exp_len != utf8d_pkg::LenNone);
   assign is_cont  = (data_byte[7:6] == utf8d_pkg::ContTag);
   assign seen_inc = seq_cur.seen + 3'd1;
   assign err_upd  = seq_cur.err | ~is_cont;

   // Shift in six payload bits if this byte is a continuation and no bad continuation was already seen.
   assign acc_upd  = (is_cont && !seq_cur.err) ? {seq_cur.acc[24:0], data_byte[5:0]}
                                               : seq_cur.acc;
   assign in_range = (acc_upd >= utf8d_pkg::low_bound(seq_cur.exp_len)) &&
                     (acc_upd <= utf8d_pkg::high_bound(seq_cur.exp_len));

   // Next state and the result item, if this byte closes one.
   always_comb begin
      seq_next       = '0;
      res_gen        = 1'b0;
      res.code_point = '0;
      res.valid_res  = 1'b0;
      res.byte_count = utf8d_pkg::LenOne;
      if (!is_open) begin
         if (lead.len == utf8d_pkg::LenOne) begin
            // Plain ASCII byte.
            res_gen        = 1'b1;
            res.code_point = {23'd0, data_byte};
            res.valid_res  = 1'b1;
         end else if (lead.len == utf8d_pkg::LenNone || end_of_buffer) begin
            // Invalid lead, or a lead with nothing after it.
            res_gen = 1'b1;
         end else begin
            seq_next.exp_len = lead.len;
            seq_next.seen    = utf8d_pkg::LenOne;
            seq_next.acc     = {23'd0, data_byte & lead.mask};
         end
      end else if (seen_inc >= seq_cur.exp_len) begin
         // Declared length reached.
         res_gen        = 1'b1;
         res.valid_res  = ~err_upd & in_range;
         res.code_point = (~err_upd & in_range) ? acc_upd : '0;
         res.byte_count = seq_cur.exp_len;
      end else if (end_of_buffer) begin
         // Truncated sequence.
         res_gen        = 1'b1;
         res.byte_count = seen_inc;
      end else begin
         seq_next.exp_len = seq_cur.exp_len;
         seq_next.seen    = seen_inc;
         seq_next.acc     = acc_upd;
         seq_next.err     = err_upd;
      end
   end

endmodule

`default_nettype wire

// ----- sv/utf8_stream_decoder.sv -----
// UTF-8 stream decoder (six-byte form): an accepted byte passes the input register, and
// then any result goes to the result register. The sequence update is one shift-and-OR
// per byte. Throughput is one byte per cycle unless a stalled result is waiting.
// Synchronous active-high reset clears the open sequence and both valid flags.
// Top level; depends on utf8d_pkg and utf8d_step.
`default_nettype none

module utf8_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_buffer,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [30:0]      rsp_code_point,
   output logic             rsp_valid_res,
   output logic [2:0]       rsp_byte_count
);

   // Input register.
   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_byte_ff, in_byte_in;
   logic                      in_eob_ff, in_eob_in;

   // Sequence state and result register.
   utf8d_pkg::seq_type        seq_ff, seq_in;
   utf8d_pkg::result_type     res_ff, res_in;
   logic                      out_valid_ff, out_valid_in;

   utf8d_pkg::seq_type        seq_step;
   utf8d_pkg::result_type     res_step;
   logic                      res_gen;
   logic                      out_free;
   logic                      proc;
   logic                      req_take;

   utf8d_step u_step (
      .seq_cur       (seq_ff),
      .data_byte     (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .seq_next      (seq_step),
      .res           (res_step),
      .res_gen       (res_gen)
   );

   // Handshake: the buffered item moves on when its result, if any, has room.
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign proc      = in_valid_ff & (out_free | ~res_gen);
   assign req_stall = in_valid_ff & ~proc;
   assign req_take  = req_valid & ~req_stall;

   // Next values of the input register.
   always_comb begin
      in_valid_in = req_take | (in_valid_ff & ~proc);
      in_byte_in  = req_take ? req_data_byte : in_byte_ff;
      in_eob_in   = req_take ? req_end_of_buffer : in_eob_ff;
   end

   // Next values of the sequence state and the result register.
   always_comb begin
      seq_in       = proc ? seq_step : seq_ff;
      out_valid_in = (proc & res_gen) | (out_valid_ff & rsp_stall);
      res_in       = (proc & res_gen) ? res_step : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seq_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         seq_ff       <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eob_ff  <= in_eob_in;
      res_ff     <= res_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = res_ff.code_point;
   assign rsp_valid_res  = res_ff.valid_res;
   assign rsp_byte_count = res_ff.byte_count;

   // An error result always carries a zero code point.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !res_ff.valid_res) |-> (res_ff.code_point == '0))
      else $error("error result with nonzero code point");

   // A result consumes one to six bytes.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (res_ff.byte_count != 3'd0 && res_ff.byte_count <= 3'd6))
      else $error("result byte count out of range");

   // An open sequence has seen at least its lead and fewer bytes than declared.
   a_seq_open: assert property (@(posedge clock) disable iff (reset)
      (seq_ff.exp_len != utf8d_pkg::LenNone) |->
         (seq_ff.seen != 3'd0 && seq_ff.seen < seq_ff.exp_len && seq_ff.exp_len <= 3'd6))
      else $error("inconsistent sequence state");

   // With the input register empty the block never stalls the sender.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("stall with empty input register");

endmodule

`default_nettype wire
